// ===== sv/todet_pkg.sv =====
// Package: shared types, codes and sizes for the time-of-day event table.
`default_nettype none

package todet_pkg;

   localparam int MAX_EVENTS  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      OP_START  = 3'd0,
      OP_ADD    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_UPDATE = 3'd3,
      OP_POLL   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_START  = 3'd0,
      KIND_ADD    = 3'd1,
      KIND_REMOVE = 3'd2,
      KIND_UPDATE = 3'd3,
      KIND_FIRED  = 3'd4,
      KIND_NONE   = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [15:0]        event_id;
      logic [16:0]        trigger_seconds;
      logic               enabled;
      logic               repeat_req;
      logic [2:0]         event_type;
      logic [15:0]        payload_tag;
      logic signed [15:0] argument;
      logic [16:0]        now_seconds;
   } req_type;

   typedef struct packed {
      logic [2:0]         result_kind;
      logic [1:0]         status;
      logic [15:0]        out_event_id;
      logic [2:0]         out_event_type;
      logic [15:0]        out_payload_tag;
      logic signed [15:0] out_argument;
      logic [16:0]        out_trigger_seconds;
      logic               last;
   } rsp_type;

   // One table entry as held by a cell.
   typedef struct packed {
      logic [15:0]        id;
      logic [16:0]        trig_sec;
      logic               enabled;
      logic               rpt;
      logic [2:0]         etype;
      logic [15:0]        payload;
      logic signed [15:0] arg;
   } entry_type;

   typedef struct packed {
      logic load;   // take the write entry
      logic shift;  // take the neighbor's entry
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/todet_cell.sv =====
// Cell: one table entry, loaded from the write bus or from its upper neighbor.
`default_nettype none

module todet_cell (
   input  wire logic                    clock,
   input  todet_pkg::cell_ctrl_type     ctrl,
   input  todet_pkg::entry_type         wr_entry,
   input  todet_pkg::entry_type         nb_entry,
   output todet_pkg::entry_type         q
);

   todet_pkg::entry_type q_ff;
   todet_pkg::entry_type q_in;

   always_comb begin
      q_in = q_ff;
      if (ctrl.load) begin
         q_in = wr_entry;
      end else if (ctrl.shift) begin
         q_in = nb_entry;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// ===== sv/time_of_day_event_table_unit.sv =====
// Top level: ordered table of time-of-day alarms built as a ring of entry cells.
//
// Requests arrive on req_valid/req_ready/req_payload; results leave on
// rsp_valid/rsp_ready/rsp_payload. A transfer happens when valid and ready are
// both high at a rising clock edge. One request is in work at a time; req_ready
// is high only while the sequencer is idle, and it does not depend on the
// result side, so a new request is taken while the previous result still sits
// in the output register.
// Start, add, remove and update latch the request in the idle state and act on
// it in the execute state, which waits while the output register is full.
// Poll rotates the whole ring of MAX_EVENTS cells once, examining the head cell
// each cycle unless the rotation is held; each fired entry, up to MAX_RESULTS,
// gives one result, the last one flagged with last, and a poll with no result
// gives a single KIND_NONE result. A stalled receiver holds the rotation only
// when a new firing meets a full output register and a full holding stage.
// Reset (synchronous, active high) empties the table, clears the id counter and
// the last-poll time; entry contents are not cleared and are never read before
// being written.
`default_nettype none

module time_of_day_event_table_unit #(
   parameter int MAX_EVENTS = todet_pkg::MAX_EVENTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  todet_pkg::req_type    req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output todet_pkg::rsp_type    rsp_payload
);

   localparam int CNT_W = $clog2(MAX_EVENTS + 1);
   localparam int RES_W = todet_pkg::RES_W;

   // Sequencer and table bookkeeping
   todet_pkg::state_type state_ff, state_in;
   todet_pkg::req_type   req_ff, req_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [15:0]          next_id_ff, next_id_in;
   logic [16:0]          last_poll_ff, last_poll_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [RES_W-1:0]     nres_ff, nres_in;

   // Holding stage for the newest firing, so the final one can carry last
   logic                 pend_valid_ff, pend_valid_in;
   todet_pkg::rsp_type   pend_ff, pend_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   todet_pkg::rsp_type   rsp_ff, rsp_in;

   // Cell ring
   todet_pkg::entry_type     cell_q    [MAX_EVENTS];
   todet_pkg::cell_ctrl_type cell_ctrl [MAX_EVENTS];
   todet_pkg::entry_type     wr_entry;
   todet_pkg::entry_type     ring_entry;
   todet_pkg::entry_type     head;

   logic [MAX_EVENTS-1:0] load_vec;
   logic [MAX_EVENTS-1:0] shift_vec;
   logic [MAX_EVENTS-1:0] match_vec;
   logic [MAX_EVENTS-1:0] first_vec;
   logic [MAX_EVENTS-1:0] above_vec;
   logic [MAX_EVENTS-1:0] add_vec;
   logic                  found;

   logic                  head_valid;
   logic                  in_window;
   logic                  head_fire;
   logic                  report;
   logic                  out_free;
   todet_pkg::rsp_type    fire_rsp;
   todet_pkg::rsp_type    ack_rsp;

   genvar gi;

   generate
      for (gi = 0; gi < MAX_EVENTS; gi++) begin : g_cell
         todet_pkg::entry_type nb;

         if (gi < MAX_EVENTS - 1) begin : g_mid
            assign nb = cell_q[gi+1];
         end else begin : g_tail
            // tail closes the ring with the (possibly disarmed) head entry
            assign nb = ring_entry;
         end

         assign cell_ctrl[gi].load  = load_vec[gi];
         assign cell_ctrl[gi].shift = shift_vec[gi];

         // match only live entries, below the fill count
         assign match_vec[gi] = (CNT_W'(gi) < cnt_ff) && (cell_q[gi].id == req_ff.event_id);
         assign add_vec[gi]   = (CNT_W'(gi) == cnt_ff);

         todet_cell u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl[gi]),
            .wr_entry (wr_entry),
            .nb_entry (nb),
            .q        (cell_q[gi])
         );
      end
   endgenerate

   // First match in table order, and every cell at or above it
   assign first_vec = match_vec & (~match_vec + MAX_EVENTS'(1));
   assign above_vec = ~(first_vec - MAX_EVENTS'(1));
   assign found     = |match_vec;

   // Write bus: an update keeps the matched id, which equals the request id
   always_comb begin
      wr_entry.id       = (req_ff.operation == todet_pkg::OP_ADD) ? next_id_ff : req_ff.event_id;
      wr_entry.trig_sec = req_ff.trigger_seconds;
      wr_entry.enabled  = req_ff.enabled;
      wr_entry.rpt      = req_ff.repeat_req;
      wr_entry.etype    = req_ff.event_type;
      wr_entry.payload  = req_ff.payload_tag;
      wr_entry.arg      = req_ff.argument;
   end

   // Head examination during a poll
   assign head       = cell_q[0];
   assign head_valid = (idx_ff < cnt_ff);

   always_comb begin
      if (last_poll_ff <= req_ff.now_seconds) begin
         in_window = (head.trig_sec > last_poll_ff) && (head.trig_sec <= req_ff.now_seconds);
      end else begin
         // window wraps across midnight
         in_window = (head.trig_sec > last_poll_ff) || (head.trig_sec <= req_ff.now_seconds);
      end
   end

   assign head_fire = head_valid && head.enabled && in_window;
   assign report    = head_fire && (nres_ff < RES_W'(todet_pkg::MAX_RESULTS));

   always_comb begin
      ring_entry = head;
      if (head_fire && !head.rpt) begin
         ring_entry.enabled = 1'b0;
      end
   end

   always_comb begin
      fire_rsp                     = '0;
      fire_rsp.result_kind         = todet_pkg::KIND_FIRED;
      fire_rsp.status              = todet_pkg::STAT_OK;
      fire_rsp.out_event_id        = head.id;
      fire_rsp.out_event_type      = head.etype;
      fire_rsp.out_payload_tag     = head.payload;
      fire_rsp.out_argument        = head.arg;
      fire_rsp.out_trigger_seconds = head.trig_sec;
      fire_rsp.last                = 1'b0;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == todet_pkg::ST_IDLE);

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      next_id_in    = next_id_ff;
      last_poll_in  = last_poll_ff;
      idx_in        = idx_ff;
      nres_in       = nres_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      load_vec      = '0;
      shift_vec     = '0;
      ack_rsp       = '0;
      ack_rsp.last  = 1'b1;

      case (state_ff)
         todet_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = todet_pkg::ST_EXEC;
            end
         end

         todet_pkg::ST_EXEC: begin
            case (req_ff.operation)
               todet_pkg::OP_START: begin
                  if (out_free) begin
                     last_poll_in        = req_ff.now_seconds;
                     ack_rsp.result_kind = todet_pkg::KIND_START;
                     rsp_in              = ack_rsp;
                     rsp_valid_in        = 1'b1;
                     state_in            = todet_pkg::ST_IDLE;
                  end
               end
               todet_pkg::OP_ADD: begin
                  if (out_free) begin
                     ack_rsp.result_kind = todet_pkg::KIND_ADD;
                     if (cnt_ff >= CNT_W'(MAX_EVENTS)) begin
                        ack_rsp.status = todet_pkg::STAT_FULL;
                     end else begin
                        load_vec             = add_vec;
                        cnt_in               = cnt_ff + CNT_W'(1);
                        ack_rsp.out_event_id = next_id_ff;
                        next_id_in           = next_id_ff + 16'd1;
                     end
                     rsp_in       = ack_rsp;
                     rsp_valid_in = 1'b1;
                     state_in     = todet_pkg::ST_IDLE;
                  end
               end
               todet_pkg::OP_REMOVE: begin
                  if (out_free) begin
                     ack_rsp.result_kind = todet_pkg::KIND_REMOVE;
                     if (found) begin
                        // close the gap: every cell from the match upward takes its neighbor
                        shift_vec = above_vec;
                        cnt_in    = cnt_ff - CNT_W'(1);
                     end else begin
                        ack_rsp.status = todet_pkg::STAT_NOT_FOUND;
                     end
                     rsp_in       = ack_rsp;
                     rsp_valid_in = 1'b1;
                     state_in     = todet_pkg::ST_IDLE;
                  end
               end
               todet_pkg::OP_UPDATE: begin
                  if (out_free) begin
                     ack_rsp.result_kind = todet_pkg::KIND_UPDATE;
                     if (found) begin
                        load_vec = first_vec;
                     end else begin
                        ack_rsp.status = todet_pkg::STAT_NOT_FOUND;
                     end
                     rsp_in       = ack_rsp;
                     rsp_valid_in = 1'b1;
                     state_in     = todet_pkg::ST_IDLE;
                  end
               end
               todet_pkg::OP_POLL: begin
                  idx_in        = '0;
                  nres_in       = '0;
                  pend_valid_in = 1'b0;
                  state_in      = todet_pkg::ST_SCAN;
               end
               default: begin
                  // unknown operation: drop it, no result
                  state_in = todet_pkg::ST_IDLE;
               end
            endcase
         end

         todet_pkg::ST_SCAN: begin
            // hold the ring when a new firing finds both output and holding stage full
            if (!(report && pend_valid_ff && !out_free)) begin
               shift_vec = '1;
               idx_in    = idx_ff + CNT_W'(1);
               if (report) begin
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in       = fire_rsp;
                  pend_valid_in = 1'b1;
                  nres_in       = nres_ff + RES_W'(1);
               end
               if (idx_ff == CNT_W'(MAX_EVENTS - 1)) begin
                  state_in = todet_pkg::ST_DONE;
               end
            end
         end

         todet_pkg::ST_DONE: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  ack_rsp.result_kind = todet_pkg::KIND_NONE;
                  rsp_in              = ack_rsp;
               end
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               last_poll_in  = req_ff.now_seconds;
               state_in      = todet_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = todet_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= todet_pkg::ST_IDLE;
         cnt_ff        <= '0;
         next_id_ff    <= '0;
         last_poll_ff  <= '0;
         idx_ff        <= '0;
         nres_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         next_id_ff    <= next_id_in;
         last_poll_ff  <= last_poll_in;
         idx_ff        <= idx_in;
         nres_ff       <= nres_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_EVENTS))
      else $error("entry count exceeds table depth");

   a_report_bound: assert property (@(posedge clock) disable iff (reset)
      nres_ff <= RES_W'(todet_pkg::MAX_RESULTS))
      else $error("reported firings exceed result limit");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == todet_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("held firing left behind after poll");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == todet_pkg::ST_DONE && state_in == todet_pkg::ST_IDLE) |=> rsp_valid_ff)
      else $error("poll finished without a final result");
`endif

endmodule

`default_nettype wire
